// ----- rtl/clook_request_scheduler_macros.svh -----
// Assertion macros used by the scheduler's port-level checker.
`ifndef CLOOK_REQUEST_SCHEDULER_MACROS_SVH
`define CLOOK_REQUEST_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crs_pkg.sv -----
// Shared types, codes and default sizes of the C-LOOK request scheduler.
package crs_pkg;

    // Default sizes
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_SECTOR_BITS = 48;
    localparam int DEF_TAG_BITS    = 8;

    // Action codes of an input request
    localparam logic [1:0] ACT_ADD      = 2'd0;
    localparam logic [1:0] ACT_DISPATCH = 2'd1;
    localparam logic [1:0] ACT_REMOVE   = 2'd2;
    localparam logic [1:0] ACT_NONE     = 2'd3;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_REMOVED    = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_FULL       = 3'd4,
        ST_NOT_FOUND  = 3'd5
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_CMP    = 3'd1,
        CMD_SCAN   = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_REMOVE = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      by_tag;   // remove the first tag match, else the dispatch pick
        logic      any_ge;   // some held sector is at or above the head
    } cell_ctrl_t;

    // Per-cell compare flags, handed to the right-hand neighbor
    typedef struct packed {
        logic gt;    // empty slot, or sector above the new request
        logic ge;    // held slot with sector at or above the head
        logic hit;   // held slot whose tag matches
        logic seen;  // some cell to the left has a tag match
    } cell_flags_t;

endpackage

// ----- rtl/crs_cell.sv -----
// One slot of the sorted request chain with its compare and shift logic.
module crs_cell #(
    parameter int SECTOR_BITS = crs_pkg::DEF_SECTOR_BITS,
    parameter int TAG_BITS    = crs_pkg::DEF_TAG_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  crs_pkg::cell_ctrl_t      ctrl,
    input  logic [SECTOR_BITS-1:0]   req_sector,
    input  logic                     req_write,
    input  logic [TAG_BITS-1:0]      req_tag,
    input  logic [SECTOR_BITS-1:0]   head,
    input  crs_pkg::cell_flags_t     left_flags,
    input  logic                     left_valid,
    input  logic [SECTOR_BITS-1:0]   left_sector,
    input  logic                     left_write,
    input  logic [TAG_BITS-1:0]      left_tag,
    input  logic                     right_valid,
    input  logic [SECTOR_BITS-1:0]   right_sector,
    input  logic                     right_write,
    input  logic [TAG_BITS-1:0]      right_tag,
    output crs_pkg::cell_flags_t     flags,
    output logic                     valid,
    output logic [SECTOR_BITS-1:0]   sector,
    output logic                     write,
    output logic [TAG_BITS-1:0]      tag
);
    import crs_pkg::*;

    logic                   valid_reg, valid_next;
    logic [SECTOR_BITS-1:0] sector_reg, sector_next;
    logic                   write_reg, write_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    cell_flags_t            flags_reg, flags_next;
    logic                   at_or_after;

    // Mark slots at or behind the one being taken out
    always_comb
    begin
        if (ctrl.by_tag)
        begin
            at_or_after = flags_reg.seen | flags_reg.hit;
        end
        else if (ctrl.any_ge)
        begin
            at_or_after = flags_reg.ge | ~valid_reg;
        end
        else
        begin
            at_or_after = 1'b1;
        end
    end

    // Compare, propagate, insert or close the gap
    always_comb
    begin
        valid_next  = valid_reg;
        sector_next = sector_reg;
        write_next  = write_reg;
        tag_next    = tag_reg;
        flags_next  = flags_reg;
        case (ctrl.cmd)
            CMD_CMP:
            begin
                flags_next.gt   = ~valid_reg | (sector_reg > req_sector);
                flags_next.ge   = valid_reg & (sector_reg >= head);
                flags_next.hit  = valid_reg & (tag_reg == req_tag);
                flags_next.seen = 1'b0;
            end
            CMD_SCAN:
            begin
                flags_next.seen = left_flags.seen | left_flags.hit;
            end
            CMD_INSERT:
            begin
                if (left_flags.gt)
                begin
                    valid_next  = left_valid;
                    sector_next = left_sector;
                    write_next  = left_write;
                    tag_next    = left_tag;
                end
                else if (flags_reg.gt)
                begin
                    valid_next  = 1'b1;
                    sector_next = req_sector;
                    write_next  = req_write;
                    tag_next    = req_tag;
                end
            end
            CMD_REMOVE:
            begin
                if (at_or_after)
                begin
                    valid_next  = right_valid;
                    sector_next = right_sector;
                    write_next  = right_write;
                    tag_next    = right_tag;
                end
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            flags_reg <= flags_next;
        end
    end

    // Hold slot payload
    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        write_reg  <= write_next;
        tag_reg    <= tag_next;
    end

    assign flags  = flags_reg;
    assign valid  = valid_reg;
    assign sector = sector_reg;
    assign write  = write_reg;
    assign tag    = tag_reg;

endmodule

// ----- rtl/clook_request_scheduler.sv -----
// Top level of the C-LOOK disk request scheduler: control and the cell chain.
//
// The scheduler holds up to QUEUE_DEPTH pending requests in a chain of cells,
// kept in ascending sector order with equal sectors first in, first out.
// It works on one request at a time: in_stall is high from the accept until
// the result has been taken. An add or a dispatch goes through a compare state
// that compares every cell, an apply state that shifts the chain and an output
// state that presents the result. A remove by tag adds scan states between
// compare and apply that pass the earlier-match mark one cell per cycle down
// the chain. A request with the unused action code is taken and gives no result.
// pending_count shows the number held after the step of the shown result.
module clook_request_scheduler #(
    parameter int QUEUE_DEPTH = crs_pkg::DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = crs_pkg::DEF_SECTOR_BITS,
    parameter int TAG_BITS    = crs_pkg::DEF_TAG_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic [SECTOR_BITS-1:0]             request_sector,
    input  logic                               request_write,
    input  logic [TAG_BITS-1:0]                request_tag,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         status,
    output logic [SECTOR_BITS-1:0]             out_sector,
    output logic                               out_write,
    output logic [TAG_BITS-1:0]                out_tag,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   pending_count
);
    import crs_pkg::*;

    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SCAN_W    = $clog2(QUEUE_DEPTH);
    localparam int SCAN_LAST = QUEUE_DEPTH - 2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_APPLY = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SCAN_W-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SECTOR_BITS-1:0] head_reg, head_next;

    logic [1:0]             action_reg;
    logic [SECTOR_BITS-1:0] req_sector_reg;
    logic                   req_write_reg;
    logic [TAG_BITS-1:0]    req_tag_reg;

    status_t                status_reg, status_next;
    logic [SECTOR_BITS-1:0] out_sector_reg, out_sector_next;
    logic                   out_write_reg, out_write_next;
    logic [TAG_BITS-1:0]    out_tag_reg, out_tag_next;

    cell_ctrl_t             ctrl;
    cell_flags_t            cell_flags  [QUEUE_DEPTH];
    logic                   cell_valid  [QUEUE_DEPTH];
    logic [SECTOR_BITS-1:0] cell_sector [QUEUE_DEPTH];
    logic                   cell_write  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    cell_tag    [QUEUE_DEPTH];

    logic [QUEUE_DEPTH-1:0] ge_vec;
    logic [QUEUE_DEPTH-1:0] ge_before;
    logic [QUEUE_DEPTH-1:0] hit_vec;
    logic [QUEUE_DEPTH-1:0] pick_vec;
    logic                   any_ge;
    logic                   found;
    logic                   in_accept;
    logic [SECTOR_BITS-1:0] pick_sector;
    logic                   pick_write;
    logic [TAG_BITS-1:0]    pick_tag;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_accept = in_valid && !in_stall;

    // Gather the chain flags and pick the slot that leaves
    always_comb
    begin
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            ge_vec[k]  = cell_flags[k].ge;
            hit_vec[k] = cell_flags[k].hit;
        end
        any_ge    = |ge_vec;
        found     = |hit_vec;
        ge_before = {ge_vec[QUEUE_DEPTH-2:0], 1'b0};
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (action_reg == ACT_REMOVE)
            begin
                pick_vec[k] = cell_flags[k].hit & ~cell_flags[k].seen;
            end
            else if (any_ge)
            begin
                pick_vec[k] = ge_vec[k] & ~ge_before[k];
            end
            else
            begin
                pick_vec[k] = (k == 0);
            end
        end
    end

    // Select the picked slot's payload
    always_comb
    begin
        pick_sector = '0;
        pick_write  = 1'b0;
        pick_tag    = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            pick_sector = pick_sector | (cell_sector[k] & {SECTOR_BITS{pick_vec[k]}});
            pick_write  = pick_write  | (cell_write[k] & pick_vec[k]);
            pick_tag    = pick_tag    | (cell_tag[k] & {TAG_BITS{pick_vec[k]}});
        end
    end

    // Sequence one request through compare, scan, apply and output
    always_comb
    begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        status_next     = status_reg;
        out_sector_next = out_sector_reg;
        out_write_next  = out_write_reg;
        out_tag_next    = out_tag_reg;
        ctrl.cmd        = CMD_HOLD;
        ctrl.by_tag     = (action_reg == ACT_REMOVE);
        ctrl.any_ge     = any_ge;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (action != ACT_NONE))
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                ctrl.cmd      = CMD_CMP;
                scan_cnt_next = '0;
                state_next    = (action_reg == ACT_REMOVE) ? S_SCAN : S_APPLY;
            end
            S_SCAN:
            begin
                ctrl.cmd      = CMD_SCAN;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SCAN_W'(SCAN_LAST))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                out_sector_next = '0;
                out_write_next  = 1'b0;
                out_tag_next    = '0;
                state_next      = S_OUT;
                if (action_reg == ACT_ADD)
                begin
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.cmd    = CMD_INSERT;
                        count_next  = count_reg + 1'b1;
                        status_next = ST_ADDED;
                    end
                end
                else if (action_reg == ACT_DISPATCH)
                begin
                    if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.cmd        = CMD_REMOVE;
                        count_next      = count_reg - 1'b1;
                        head_next       = pick_sector;
                        status_next     = ST_DISPATCHED;
                        out_sector_next = pick_sector;
                        out_write_next  = pick_write;
                        out_tag_next    = pick_tag;
                    end
                end
                else
                begin
                    if (!found)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        ctrl.cmd     = CMD_REMOVE;
                        count_next   = count_reg - 1'b1;
                        status_next  = ST_REMOVED;
                        out_tag_next = pick_tag;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            scan_cnt_reg <= '0;
            count_reg    <= '0;
            head_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
        end
    end

    // Capture the request and hold the result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg     <= action;
            req_sector_reg <= request_sector;
            req_write_reg  <= request_write;
            req_tag_reg    <= request_tag;
        end
        status_reg     <= status_next;
        out_sector_reg <= out_sector_next;
        out_write_reg  <= out_write_next;
        out_tag_reg    <= out_tag_next;
    end

    // Build the chain, closing both ends with empty slots
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        cell_flags_t            lf;
        logic                   lv;
        logic [SECTOR_BITS-1:0] ls;
        logic                   lw;
        logic [TAG_BITS-1:0]    lt;
        logic                   rv;
        logic [SECTOR_BITS-1:0] rs;
        logic                   rw;
        logic [TAG_BITS-1:0]    rt;

        if (k == 0)
        begin : g_left_end
            assign lf = '0;
            assign lv = 1'b0;
            assign ls = '0;
            assign lw = 1'b0;
            assign lt = '0;
        end
        else
        begin : g_left
            assign lf = cell_flags[k-1];
            assign lv = cell_valid[k-1];
            assign ls = cell_sector[k-1];
            assign lw = cell_write[k-1];
            assign lt = cell_tag[k-1];
        end

        if (k == QUEUE_DEPTH - 1)
        begin : g_right_end
            assign rv = 1'b0;
            assign rs = '0;
            assign rw = 1'b0;
            assign rt = '0;
        end
        else
        begin : g_right
            assign rv = cell_valid[k+1];
            assign rs = cell_sector[k+1];
            assign rw = cell_write[k+1];
            assign rt = cell_tag[k+1];
        end

        crs_cell #(
            .SECTOR_BITS (SECTOR_BITS),
            .TAG_BITS    (TAG_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .req_sector   (req_sector_reg),
            .req_write    (req_write_reg),
            .req_tag      (req_tag_reg),
            .head         (head_reg),
            .left_flags   (lf),
            .left_valid   (lv),
            .left_sector  (ls),
            .left_write   (lw),
            .left_tag     (lt),
            .right_valid  (rv),
            .right_sector (rs),
            .right_write  (rw),
            .right_tag    (rt),
            .flags        (cell_flags[k]),
            .valid        (cell_valid[k]),
            .sector       (cell_sector[k]),
            .write        (cell_write[k]),
            .tag          (cell_tag[k])
        );
    end

    assign status        = status_reg;
    assign out_sector    = out_sector_reg;
    assign out_write     = out_write_reg;
    assign out_tag       = out_tag_reg;
    assign pending_count = count_reg;

endmodule

// ----- rtl/crs_checker.sv -----
// Port-level checks of the scheduler and their bind to the top level.
`include "clook_request_scheduler_macros.svh"

module crs_checker #(
    parameter int QUEUE_DEPTH = crs_pkg::DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = crs_pkg::DEF_SECTOR_BITS,
    parameter int TAG_BITS    = crs_pkg::DEF_TAG_BITS
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic [1:0]                         action,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [2:0]                         status,
    input logic [SECTOR_BITS-1:0]             out_sector,
    input logic                               out_write,
    input logic [TAG_BITS-1:0]                out_tag,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0]   pending_count
);
    import crs_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // A real request closes the input until its result is taken
    `CRS_ASSERT_NXT(a_one_at_a_time, in_valid && !in_stall && action != ACT_NONE, in_stall, "request taken while another is in flight")

    // A stalled result stays shown and unchanged
    `CRS_ASSERT_NXT(a_hold_result, out_valid && out_stall, out_valid && $stable(status) && $stable(out_sector) && $stable(out_write) && $stable(out_tag) && $stable(pending_count), "stalled result changed")

    // A full status only with a full table
    `CRS_ASSERT_IMP(a_full_count, out_valid && status == ST_FULL, pending_count == CNT_W'(QUEUE_DEPTH), "full status with room left")

    // An empty status only with an empty table and no data
    `CRS_ASSERT_IMP(a_empty_count, out_valid && status == ST_EMPTY, pending_count == '0 && out_sector == '0 && !out_write && out_tag == '0, "empty status with requests held or data shown")

    // Count never exceeds the table size
    `CRS_ASSERT_IMP(a_count_range, out_valid, pending_count <= CNT_W'(QUEUE_DEPTH), "pending count beyond table size")

endmodule

bind clook_request_scheduler crs_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .SECTOR_BITS (SECTOR_BITS),
    .TAG_BITS    (TAG_BITS)
) u_crs_checker (.*);

// ----- dv/clook_request_scheduler_checker.sv -----
`timescale 1ns / 100ps
// Scheduler checker: predicts the result of each taken request and compares it field by field.
module clook_request_scheduler_checker #(
    parameter int QUEUE_DEPTH = crs_pkg::DEF_QUEUE_DEPTH,
    parameter int SECTOR_BITS = crs_pkg::DEF_SECTOR_BITS,
    parameter int TAG_BITS    = crs_pkg::DEF_TAG_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic [SECTOR_BITS-1:0]             request_sector,
    input  logic                               request_write,
    input  logic [TAG_BITS-1:0]                request_tag,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [2:0]                         status,
    input  logic [SECTOR_BITS-1:0]             out_sector,
    input  logic                               out_write,
    input  logic [TAG_BITS-1:0]                out_tag,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   pending_count,
    output int                                 fail_count,
    output int                                 waiting_count
);
    import crs_pkg::*;

    localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        status_t                st;
        logic [SECTOR_BITS-1:0] sector;
        logic                   wr;
        logic [TAG_BITS-1:0]    tag;
        logic [COUNT_W-1:0]     count;
    } sched_result_t;

    // Shadow copy of the sorted request table
    logic [SECTOR_BITS-1:0] held_sector [QUEUE_DEPTH];
    logic                   held_write  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    held_tag    [QUEUE_DEPTH];
    int                     held_total;
    logic [SECTOR_BITS-1:0] head_sector;

    sched_result_t due_results [$];
    int            mismatch_total;

    // Close the gap left by a request taken out of the table
    task automatic drop_slot(input int at);
        int k;
        for (k = at; k + 1 < held_total; k++)
        begin
            held_sector[k] = held_sector[k + 1];
            held_write[k]  = held_write[k + 1];
            held_tag[k]    = held_tag[k + 1];
        end
        held_total--;
    endtask

    // Apply one request to the shadow table and work out its result
    task automatic schedule_step(
        input  logic [1:0]             act,
        input  logic [SECTOR_BITS-1:0] sec,
        input  logic                   wr,
        input  logic [TAG_BITS-1:0]    tg,
        output sched_result_t          res
    );
        int k;
        int pos;
        bit found;
        res = '0;
        found = 1'b0;
        case (act)
            ACT_ADD:
            begin
                if (held_total >= QUEUE_DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    // insert after every equal or lower sector
                    pos = held_total;
                    for (k = 0; k < held_total; k++)
                    begin
                        if (!found && held_sector[k] > sec)
                        begin
                            pos = k;
                            found = 1'b1;
                        end
                    end
                    for (k = held_total; k > pos; k--)
                    begin
                        held_sector[k] = held_sector[k - 1];
                        held_write[k]  = held_write[k - 1];
                        held_tag[k]    = held_tag[k - 1];
                    end
                    held_sector[pos] = sec;
                    held_write[pos]  = wr;
                    held_tag[pos]    = tg;
                    held_total++;
                    res.st = ST_ADDED;
                end
            end
            ACT_DISPATCH:
            begin
                if (held_total == 0)
                    res.st = ST_EMPTY;
                else
                begin
                    // first sector at or above the head, else wrap to the lowest
                    pos = 0;
                    for (k = 0; k < held_total; k++)
                    begin
                        if (!found && held_sector[k] >= head_sector)
                        begin
                            pos = k;
                            found = 1'b1;
                        end
                    end
                    res.sector  = held_sector[pos];
                    res.wr      = held_write[pos];
                    res.tag     = held_tag[pos];
                    head_sector = held_sector[pos];
                    drop_slot(pos);
                    res.st = ST_DISPATCHED;
                end
            end
            default:
            begin
                // lowest-sector tag match wins
                pos = 0;
                for (k = 0; k < held_total; k++)
                begin
                    if (!found && held_tag[k] == tg)
                    begin
                        pos = k;
                        found = 1'b1;
                    end
                end
                if (!found)
                    res.st = ST_NOT_FOUND;
                else
                begin
                    res.tag = held_tag[pos];
                    drop_slot(pos);
                    res.st = ST_REMOVED;
                end
            end
        endcase
        res.count = COUNT_W'(held_total);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        sched_result_t got;
        if (!rst_n)
        begin
            held_total     = 0;
            head_sector    = '0;
            mismatch_total = 0;
            due_results.delete();
            fail_count    <= 0;
            waiting_count <= 0;
        end
        else
        begin
            // Compare a taken result with the oldest prediction
            if (out_valid && !out_stall)
            begin
                got.st     = status_t'(status);
                got.sector = out_sector;
                got.wr     = out_write;
                got.tag    = out_tag;
                got.count  = pending_count;
                if (due_results.size() == 0)
                begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT)
                        $display("%0t: result with no request pending: status %0d tag %h count %0d",
                                 $time, status, out_tag, pending_count);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected status %0d sector %h write %b",
                                     $time, want.st, want.sector, want.wr,
                                     " tag %h count %0d,", want.tag, want.count,
                                     " got status %0d sector %h write %b",
                                     status, out_sector, out_write,
                                     " tag %h count %0d", out_tag, pending_count);
                    end
                end
            end
            // Predict the result of a taken request; the unused action gives none
            if (in_valid && !in_stall && action != ACT_NONE)
            begin
                schedule_step(action, request_sector, request_write, request_tag, want);
                due_results.push_back(want);
            end
            fail_count    <= mismatch_total;
            waiting_count <= due_results.size();
        end
    end

endmodule

// ----- dv/tb_clook_request_scheduler.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, request stimulus, output stalls and the verdict for the scheduler.
module tb_clook_request_scheduler;
    import crs_pkg::*;

    localparam int QD              = DEF_QUEUE_DEPTH;
    localparam int SB              = DEF_SECTOR_BITS;
    localparam int TB              = DEF_TAG_BITS;
    localparam int CW              = $clog2(QD + 1);
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_REQUESTS = 1800;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 500;
    localparam logic [SB-1:0] SECTOR_MAX = '1;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [1:0]    action;
    logic [SB-1:0] request_sector;
    logic          request_write;
    logic [TB-1:0] request_tag;
    logic          out_valid;
    logic          out_stall;
    logic [2:0]    status;
    logic [SB-1:0] out_sector;
    logic          out_write;
    logic [TB-1:0] out_tag;
    logic [CW-1:0] pending_count;
    int            fail_count;
    int            waiting_count;
    int            results_taken;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    clook_request_scheduler u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .request_sector (request_sector),
        .request_write  (request_write),
        .request_tag    (request_tag),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_sector     (out_sector),
        .out_write      (out_write),
        .out_tag        (out_tag),
        .pending_count  (pending_count)
    );

    clook_request_scheduler_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .request_sector (request_sector),
        .request_write  (request_write),
        .request_tag    (request_tag),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .out_sector     (out_sector),
        .out_write      (out_write),
        .out_tag        (out_tag),
        .pending_count  (pending_count),
        .fail_count     (fail_count),
        .waiting_count  (waiting_count)
    );

    // Count results taken, to place the long output hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_taken <= 0;
        else if (out_valid && !out_stall)
            results_taken <= results_taken + 1;
    end

    // Abort a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_clook_request_scheduler: done, errors");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Favor a small sector range so equal sectors are common
    function automatic logic [SB-1:0] pick_sector();
        int r;
        logic [63:0] wide;
        r = $urandom_range(0, 99);
        wide = {$urandom, $urandom};
        if (r < 50)
            return SB'($urandom_range(0, 31));
        if (r < 85)
            return wide[SB-1:0];
        case ($urandom_range(0, 3))
            0: return '0;
            1: return SB'(1);
            2: return SECTOR_MAX - 1'b1;
            default: return SECTOR_MAX;
        endcase
    endfunction

    // Favor a few tags so removes often hit
    function automatic logic [TB-1:0] pick_tag();
        if ($urandom_range(0, 3) != 0)
            return TB'($urandom_range(0, 15));
        return TB'($urandom_range(0, 255));
    endfunction

    // Fill, balance or drain the table depending on the phase
    function automatic logic [1:0] pick_action(input int phase);
        int r;
        int add_share;
        r = $urandom_range(0, 99);
        add_share = (phase == 0) ? 65 : (phase == 2) ? 20 : 40;
        if (r < 3)
            return ACT_NONE;
        if (r < 3 + add_share)
            return ACT_ADD;
        if (r >= 83)
            return ACT_REMOVE;
        return ACT_DISPATCH;
    endfunction

    // Offer one request after a gap and hold it until taken; call at a falling edge
    task automatic send_request(
        input logic [1:0]    act,
        input logic [SB-1:0] sec,
        input logic          wr,
        input logic [TB-1:0] tg,
        input bit            quiet
    );
        int gap;
        gap = pick_gap(quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        action         <= act;
        request_sector <= sec;
        request_write  <= wr;
        request_tag    <= tg;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Stall the output in runs, with one long hold-off
    initial
    begin
        int  run_left;
        int  r;
        bit  stall_now;
        bit  held_off;
        out_stall = 1'b0;
        run_left  = 0;
        stall_now = 1'b0;
        held_off  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (!held_off && results_taken >= HOLD_OFF_AFTER)
                begin
                    held_off  = 1'b1;
                    stall_now = 1'b1;
                    run_left  = HOLD_OFF_CYCLES;
                end
                else if (results_taken % 350 < 50)
                begin
                    stall_now = 1'b0;
                    run_left  = 8;
                end
                else if (r < 50)
                begin
                    stall_now = 1'b0;
                    run_left  = $urandom_range(1, 6);
                end
                else
                begin
                    stall_now = 1'b1;
                    run_left  = (r < 80) ? $urandom_range(1, 3) :
                                (r < 95) ? $urandom_range(4, 10) : $urandom_range(20, 60);
                end
            end
            out_stall <= stall_now;
            run_left--;
        end
    end

    // Reset, directed requests, random requests, drain and verdict
    initial
    begin
        int         i;
        int         phase;
        bit         quiet;
        logic [1:0] act;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = ACT_NONE;
        request_sector = '0;
        request_write  = 1'b0;
        request_tag    = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table: dispatch finds nothing, remove misses, unused action is dropped
        send_request(ACT_DISPATCH, '0, 1'b0, 8'h00, 1'b0);
        send_request(ACT_REMOVE, '0, 1'b0, 8'hA5, 1'b0);
        send_request(ACT_NONE, SECTOR_MAX, 1'b1, 8'hFF, 1'b0);

        // fill the table: extremes, equal sectors in arrival order, a duplicate tag
        send_request(ACT_ADD, SB'(100), 1'b0, 8'h00, 1'b0);
        send_request(ACT_ADD, '0, 1'b1, 8'hFF, 1'b0);
        send_request(ACT_ADD, SECTOR_MAX, 1'b1, 8'h11, 1'b0);
        send_request(ACT_ADD, SB'(100), 1'b1, 8'h22, 1'b0);
        send_request(ACT_ADD, SB'(100), 1'b0, 8'h00, 1'b0);
        send_request(ACT_ADD, SB'(50), 1'b0, 8'h33, 1'b0);
        send_request(ACT_ADD, SB'(200), 1'b1, 8'h44, 1'b0);
        send_request(ACT_ADD, SECTOR_MAX, 1'b0, 8'h55, 1'b0);
        send_request(ACT_ADD, '0, 1'b0, 8'h66, 1'b0);
        send_request(ACT_ADD, SB'(7), 1'b1, 8'h77, 1'b0);
        send_request(ACT_ADD, 48'h8000_0000_0000, 1'b0, 8'h88, 1'b0);
        send_request(ACT_ADD, 48'h5555_5555_5555, 1'b1, 8'h99, 1'b0);
        send_request(ACT_ADD, 48'hAAAA_AAAA_AAAA, 1'b0, 8'hAA, 1'b0);
        send_request(ACT_ADD, SB'(300), 1'b1, 8'hBB, 1'b0);
        send_request(ACT_ADD, SB'(100), 1'b1, 8'hCC, 1'b0);
        send_request(ACT_ADD, SB'(1), 1'b0, 8'hDD, 1'b0);

        // full table rejects, duplicate tag at one sector goes earliest arrival first, then serve a few
        send_request(ACT_ADD, SB'(9), 1'b1, 8'hEE, 1'b0);
        send_request(ACT_REMOVE, '0, 1'b0, 8'h00, 1'b0);
        send_request(ACT_DISPATCH, '0, 1'b0, 8'h00, 1'b0);
        send_request(ACT_DISPATCH, '0, 1'b0, 8'h00, 1'b0);
        send_request(ACT_DISPATCH, '0, 1'b0, 8'h00, 1'b0);
        send_request(ACT_REMOVE, '0, 1'b0, 8'h5A, 1'b0);

        // random requests in fill, balance and drain phases
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == RANDOM_REQUESTS / 2)
            begin
                // hold off until every result is back
                in_valid <= 1'b0;
                do @(posedge clk); while (waiting_count != 0);
                @(negedge clk);
            end
            phase = (i / 150) % 4;
            quiet = (i % 300) < 40;
            act   = pick_action(phase);
            send_request(act, pick_sector(), 1'($urandom_range(0, 1)), pick_tag(), quiet);
        end
        in_valid <= 1'b0;

        // drain and let the block settle
        do @(posedge clk); while (waiting_count != 0);
        repeat (3 * QD) @(posedge clk);
        if (fail_count == 0)
            $display("tb_clook_request_scheduler: done, clean");
        else
            $display("tb_clook_request_scheduler: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/crs_pkg.sv
rtl/crs_cell.sv
rtl/clook_request_scheduler.sv
rtl/crs_checker.sv
dv/clook_request_scheduler_checker.sv
dv/tb_clook_request_scheduler.sv
